[src/tvml_pkg.sv]
// ----------------------------------------------------------------------------
// tvml_pkg
// Shared types and constants of the tetrahedron volume / lumped mass unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tvml_pkg;

  // default vertex capacity
  localparam int MAX_VERTICES_DEF = 4096;

  // field widths
  localparam int KIND_W  = 3;
  localparam int IDX_W   = 12;
  localparam int COORD_W = 24;
  localparam int DENS_W  = 32;
  localparam int Q_W     = 64;
  localparam int MEAN_W  = 32;

  // packed channel widths
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 352;

  // request kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ELEM   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TOTALS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // decoded operation
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_BEGIN,
    OP_ELEM,
    OP_TOTALS,
    OP_READ,
    OP_NONE
  } op_t;

  // classified request held in the queue
  typedef struct packed {
    op_t                             op;
    logic [IDX_W-1:0]                vertex_index;
    logic                            vertex_ok;
    logic signed [COORD_W-1:0]       coord_x;
    logic signed [COORD_W-1:0]       coord_y;
    logic signed [COORD_W-1:0]       coord_z;
    logic [3:0][IDX_W-1:0]           corner;
    logic [3:0]                      corner_ok;
    logic [DENS_W-1:0]               density;
  } item_t;

  // one result
  typedef struct packed {
    logic [Q_W-1:0]    elem_volume;
    logic [Q_W-1:0]    elem_mass;
    logic [Q_W-1:0]    vertex_mass;
    logic [Q_W-1:0]    sum_volume;
    logic [Q_W-1:0]    sum_mass;
    logic [MEAN_W-1:0] mean_density;
    logic              no_volume;
  } res_t;

endpackage

`default_nettype wire

[src/tet_volume_mass_lumping_unit.sv]
// ----------------------------------------------------------------------------
// tet_volume_mass_lumping_unit
// Tetrahedron volume and lumped vertex mass unit, fixed point, stream ports.
// ----------------------------------------------------------------------------
// Each request gives exactly one result, in order. A front stage decodes and
// queues up to two requests while the back sequencer works on one at a time
// and a result register holds the answer until it is taken. In the back, a
// totals request that computes a mean takes one quotient bit per cycle; an
// element runs four single-port vertex reads, twelve determinant steps through
// one 27x27 multiplier, seventeen radix-16 digits of the divide by three, two
// 32x32 mass products and four read-modify-write pairs on the single-port mass
// memory; a begin pass sweeps the mass memory to zero one entry a cycle. After
// reset the same sweep runs with in_tready low.
`default_nettype none

module tet_volume_mass_lumping_unit #(
  parameter int MAX_VERTICES = tvml_pkg::MAX_VERTICES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // request channel
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
  // corner_d, density, zero pad
  input  wire [tvml_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind
  input  wire [tvml_pkg::KIND_W-1:0]         in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // elem_volume, elem_mass, vertex_mass, sum_volume, sum_mass, mean_density
  output logic [tvml_pkg::OUT_DATA_W-1:0]    out_tdata,
  // no_volume
  output logic                               out_tuser
);

  logic            q_valid;
  logic            q_ready;
  logic            init_busy;
  tvml_pkg::item_t q_item;
  tvml_pkg::res_t  res;

  // request decode and queue
  tvml_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // execution sequencer
  tvml_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .init_busy (init_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result packing
  assign out_tdata = {res.mean_density, res.sum_mass, res.sum_volume,
                      res.vertex_mass, res.elem_mass, res.elem_volume};
  assign out_tuser = res.no_volume;

endmodule

`default_nettype wire

[src/tvml_front.sv]
// ----------------------------------------------------------------------------
// tvml_front
// Accepts requests, decodes the kind, range-checks indices and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module tvml_front #(
  parameter int MAX_VERTICES = tvml_pkg::MAX_VERTICES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [tvml_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire [tvml_pkg::KIND_W-1:0]        in_tuser,
  input  wire                               init_busy,
  output logic                              q_valid,
  input  wire                               q_ready,
  output tvml_pkg::item_t                   q_item
);

  tvml_pkg::item_t item_c;
  tvml_pkg::item_t ent_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            pop;

  // decode and range check
  always_comb begin
    item_c              = '0;
    item_c.vertex_index = in_tdata[11:0];
    item_c.coord_x      = in_tdata[35:12];
    item_c.coord_y      = in_tdata[59:36];
    item_c.coord_z      = in_tdata[83:60];
    item_c.corner[0]    = in_tdata[95:84];
    item_c.corner[1]    = in_tdata[107:96];
    item_c.corner[2]    = in_tdata[119:108];
    item_c.corner[3]    = in_tdata[131:120];
    item_c.density      = in_tdata[163:132];
    item_c.vertex_ok    = 32'(item_c.vertex_index) < 32'(MAX_VERTICES);
    for (int k = 0; k < 4; k++) begin
      item_c.corner_ok[k] = 32'(item_c.corner[k]) < 32'(MAX_VERTICES);
    end
    unique case (in_tuser)
      tvml_pkg::KIND_LOAD:   item_c.op = tvml_pkg::OP_LOAD;
      tvml_pkg::KIND_BEGIN:  item_c.op = tvml_pkg::OP_BEGIN;
      tvml_pkg::KIND_ELEM:   item_c.op = tvml_pkg::OP_ELEM;
      tvml_pkg::KIND_TOTALS: item_c.op = tvml_pkg::OP_TOTALS;
      tvml_pkg::KIND_READ:   item_c.op = tvml_pkg::OP_READ;
      default:               item_c.op = tvml_pkg::OP_NONE;
    endcase
  end

  // two-entry queue
  assign in_tready = (cnt_r != 2'd2) && !init_busy;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= item_c;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

[src/tvml_back.sv]
// ----------------------------------------------------------------------------
// tvml_back
// Sequencer that carries out one request at a time: vertex and mass memories,
// determinant, divide by three, mass product, lumping, totals, mean density.
// ----------------------------------------------------------------------------
`default_nettype none

module tvml_back #(
  parameter int MAX_VERTICES = tvml_pkg::MAX_VERTICES_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  output logic             q_ready,
  input  tvml_pkg::item_t  q_item,
  output logic             init_busy,
  output logic             out_valid,
  input  wire              out_ready,
  output tvml_pkg::res_t   out_res
);

  localparam int AW = $clog2(MAX_VERTICES);

  localparam logic [5:0] RD_LAST    = 6'd4;
  localparam logic [5:0] MUL_OPS    = 6'd12;
  localparam logic [5:0] DIV3_LAST  = 6'd16;
  localparam logic [5:0] SHARE_LAST = 6'd7;
  localparam logic [5:0] MEAN_LAST  = 6'd31;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_RD, S_DIFF, S_MUL, S_ABS, S_DIV3,
    S_MASS, S_SHARE, S_TOT, S_RDM, S_MEAN, S_DONE
  } state_t;

  // one multiply-accumulate step of the determinant
  typedef struct packed {
    logic [2:0] a;
    logic [3:0] b;
    logic       neg;
    logic       sh;
    logic       last;
    logic [1:0] grp;
  } mop_t;

  function automatic mop_t mop_of(input logic [3:0] n);
    mop_t m;
    m = '0;
    case (n)
      4'd0:  begin m.a = 3'd1; m.b = 4'd2; end
      4'd1:  begin m.a = 3'd2; m.b = 4'd1; m.neg = 1'b1; m.last = 1'b1; m.grp = 2'd0; end
      4'd2:  begin m.a = 3'd2; m.b = 4'd0; end
      4'd3:  begin m.a = 3'd0; m.b = 4'd2; m.neg = 1'b1; m.last = 1'b1; m.grp = 2'd1; end
      4'd4:  begin m.a = 3'd0; m.b = 4'd1; end
      4'd5:  begin m.a = 3'd1; m.b = 4'd0; m.neg = 1'b1; m.last = 1'b1; m.grp = 2'd2; end
      4'd6:  begin m.a = 3'd3; m.b = 4'd3; end
      4'd7:  begin m.a = 3'd3; m.b = 4'd6; m.sh = 1'b1; end
      4'd8:  begin m.a = 3'd4; m.b = 4'd4; end
      4'd9:  begin m.a = 3'd4; m.b = 4'd7; m.sh = 1'b1; end
      4'd10: begin m.a = 3'd5; m.b = 4'd5; end
      4'd11: begin m.a = 3'd5; m.b = 4'd8; m.sh = 1'b1; m.last = 1'b1; m.grp = 2'd3; end
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [tvml_pkg::IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[AW-1:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    return s[64] ? '1 : s[63:0];
  endfunction

  // control and datapath registers
  state_t                   state_r;
  logic                     init_r;
  logic [5:0]               step_r;
  logic [AW-1:0]            clr_r;
  tvml_pkg::item_t          item_r;
  tvml_pkg::res_t           res_r;
  logic                     out_valid_r;
  tvml_pkg::res_t           out_res_r;

  logic signed [23:0]       px_r [4];
  logic signed [23:0]       py_r [4];
  logic signed [23:0]       pz_r [4];
  logic signed [24:0]       u_r [3];
  logic signed [24:0]       v_r [3];
  logic signed [24:0]       w_r [3];
  logic signed [53:0]       dm_p_r;
  mop_t                     dm_m_r;
  logic                     dm_v_r;
  logic signed [79:0]       acc_r;
  logic signed [50:0]       c_r [3];
  logic signed [79:0]       det_r;

  logic [67:0]              dx_r;
  logic [1:0]               dr_r;
  logic [67:0]              dq_r;
  logic [63:0]              vol_r;
  logic [63:0]              mp_r;
  logic [95:0]              prod_r;
  logic [63:0]              mass_r;
  logic [63:0]              vol_tot_r;
  logic [63:0]              mass_tot_r;
  logic [63:0]              mr_r;
  logic [31:0]              mn_r;
  logic [31:0]              mq_r;

  // memories
  logic [71:0]              vmem [MAX_VERTICES];
  logic [71:0]              vm_rdata_r;
  logic [63:0]              mmem [MAX_VERTICES];
  logic [63:0]              mm_rdata_r;

  logic                     vm_we;
  logic [AW-1:0]            vm_addr;
  logic [71:0]              vm_wdata;
  logic                     mm_we;
  logic [AW-1:0]            mm_addr;
  logic [63:0]              mm_wdata;

  // combinational helpers
  mop_t                     mop;
  logic signed [26:0]       a_op;
  logic signed [26:0]       b_op;
  logic signed [79:0]       term;
  logic signed [79:0]       acc_nxt;
  logic signed [79:0]       mag;
  logic [5:0]               t6;
  logic [11:0]              qd12;
  logic [3:0]               qd;
  logic [5:0]               r6;
  logic [63:0]              vol_c;
  logic [63:0]              mass_c;
  logic [64:0]              mt65;
  logic [64:0]              mdif65;
  logic                     mge;
  logic [63:0]              mr_nxt;
  logic [1:0]               rd_k;

  assign q_ready   = (state_r == S_IDLE);
  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // memory port control
  always_comb begin
    vm_we    = 1'b0;
    vm_addr  = to_addr(item_r.vertex_index);
    vm_wdata = {item_r.coord_z, item_r.coord_y, item_r.coord_x};
    mm_we    = 1'b0;
    mm_addr  = to_addr(item_r.vertex_index);
    mm_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mm_we   = 1'b1;
        mm_addr = clr_r;
      end
      S_DISP: begin
        if (item_r.op == tvml_pkg::OP_LOAD && item_r.vertex_ok) begin
          vm_we = 1'b1;
        end
      end
      S_RD: begin
        vm_addr = to_addr(item_r.corner[step_r[1:0]]);
      end
      S_SHARE: begin
        mm_addr = to_addr(item_r.corner[step_r[2:1]]);
        if (step_r[0] && item_r.corner_ok[step_r[2:1]]) begin
          mm_we    = 1'b1;
          mm_wdata = sat_add(mm_rdata_r, {2'b00, mass_r[63:2]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_addr] <= vm_wdata;
    end
    vm_rdata_r <= vmem[vm_addr];
  end

  always_ff @(posedge clk) begin
    if (mm_we) begin
      mmem[mm_addr] <= mm_wdata;
    end
    mm_rdata_r <= mmem[mm_addr];
  end

  // determinant operand selection and accumulate
  always_comb begin
    mop = mop_of(step_r[3:0]);
    case (mop.a)
      3'd0:    a_op = 27'(v_r[0]);
      3'd1:    a_op = 27'(v_r[1]);
      3'd2:    a_op = 27'(v_r[2]);
      3'd3:    a_op = 27'(u_r[0]);
      3'd4:    a_op = 27'(u_r[1]);
      default: a_op = 27'(u_r[2]);
    endcase
    case (mop.b)
      4'd0:    b_op = 27'(w_r[0]);
      4'd1:    b_op = 27'(w_r[1]);
      4'd2:    b_op = 27'(w_r[2]);
      4'd3:    b_op = signed'({1'b0, c_r[0][25:0]});
      4'd4:    b_op = signed'({1'b0, c_r[1][25:0]});
      4'd5:    b_op = signed'({1'b0, c_r[2][25:0]});
      4'd6:    b_op = 27'(signed'(c_r[0][50:26]));
      4'd7:    b_op = 27'(signed'(c_r[1][50:26]));
      default: b_op = 27'(signed'(c_r[2][50:26]));
    endcase
    term    = dm_m_r.sh ? (80'(dm_p_r) <<< 26) : 80'(dm_p_r);
    acc_nxt = dm_m_r.neg ? (acc_r - term) : (acc_r + term);
  end

  // magnitude, divide-by-three digit, mass and mean division steps
  always_comb begin
    mag    = det_r[79] ? -det_r : det_r;
    t6     = {dr_r, dx_r[67:64]};
    qd12   = 12'(t6) * 12'd43;
    qd     = qd12[10:7];
    r6     = t6 - 6'(6'(qd) * 6'd3);
    vol_c  = (dq_r[67:64] != 4'd0) ? '1 : dq_r[63:0];
    mass_c = (prod_r[95:80] != 16'd0) ? '1 : prod_r[79:16];
    mt65   = {mr_r, mn_r[31]};
    mdif65 = mt65 - {1'b0, vol_tot_r};
    mge    = (mt65 >= {1'b0, vol_tot_r});
    mr_nxt = mge ? mdif65[63:0] : mt65[63:0];
    rd_k   = step_r[1:0] - 2'd1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      step_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      dm_v_r      <= 1'b0;
      vol_tot_r   <= '0;
      mass_tot_r  <= '0;
    end else begin
      dm_v_r <= (state_r == S_MUL) && (step_r < MUL_OPS);
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // determinant accumulator
      if (dm_v_r) begin
        if (dm_m_r.last) begin
          acc_r <= '0;
          if (dm_m_r.grp == 2'd3) begin
            det_r <= acc_nxt;
          end else begin
            c_r[dm_m_r.grp] <= acc_nxt[50:0];
          end
        end else begin
          acc_r <= acc_nxt;
        end
      end

      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == AW'(MAX_VERTICES - 1)) begin
            clr_r <= '0;
            if (init_r) begin
              init_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            res_r   <= '0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          step_r <= '0;
          unique case (item_r.op)
            tvml_pkg::OP_BEGIN: begin
              vol_tot_r  <= '0;
              mass_tot_r <= '0;
              state_r    <= S_CLEAR;
            end
            tvml_pkg::OP_ELEM: begin
              state_r <= S_RD;
            end
            tvml_pkg::OP_TOTALS: begin
              res_r.sum_volume <= vol_tot_r;
              res_r.sum_mass   <= mass_tot_r;
              if (vol_tot_r == '0) begin
                res_r.no_volume <= 1'b1;
                state_r         <= S_DONE;
              end else if ({16'd0, mass_tot_r[63:16]} >= vol_tot_r) begin
                res_r.mean_density <= '1;
                state_r            <= S_DONE;
              end else begin
                mr_r    <= {16'd0, mass_tot_r[63:16]};
                mn_r    <= {mass_tot_r[15:0], 16'd0};
                state_r <= S_MEAN;
              end
            end
            tvml_pkg::OP_READ: begin
              state_r <= item_r.vertex_ok ? S_RDM : S_DONE;
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_RD: begin
          step_r <= step_r + 1'b1;
          if (step_r != 6'd0) begin
            if (item_r.corner_ok[rd_k]) begin
              px_r[rd_k] <= vm_rdata_r[23:0];
              py_r[rd_k] <= vm_rdata_r[47:24];
              pz_r[rd_k] <= vm_rdata_r[71:48];
            end else begin
              px_r[rd_k] <= '0;
              py_r[rd_k] <= '0;
              pz_r[rd_k] <= '0;
            end
          end
          if (step_r == RD_LAST) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          u_r[0]  <= 25'(px_r[1]) - 25'(px_r[0]);
          u_r[1]  <= 25'(py_r[1]) - 25'(py_r[0]);
          u_r[2]  <= 25'(pz_r[1]) - 25'(pz_r[0]);
          v_r[0]  <= 25'(px_r[2]) - 25'(px_r[0]);
          v_r[1]  <= 25'(py_r[2]) - 25'(py_r[0]);
          v_r[2]  <= 25'(pz_r[2]) - 25'(pz_r[0]);
          w_r[0]  <= 25'(px_r[3]) - 25'(px_r[0]);
          w_r[1]  <= 25'(py_r[3]) - 25'(py_r[0]);
          w_r[2]  <= 25'(pz_r[3]) - 25'(pz_r[0]);
          acc_r   <= '0;
          step_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (step_r < MUL_OPS) begin
            dm_p_r <= a_op * b_op;
            dm_m_r <= mop;
            step_r <= step_r + 1'b1;
          end else begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          dx_r    <= mag[76:9];
          dr_r    <= '0;
          dq_r    <= '0;
          step_r  <= '0;
          state_r <= S_DIV3;
        end
        S_DIV3: begin
          dx_r <= {dx_r[63:0], 4'd0};
          dr_r <= r6[1:0];
          dq_r <= {dq_r[63:0], qd};
          if (step_r == DIV3_LAST) begin
            step_r  <= '0;
            state_r <= S_MASS;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_MASS: begin
          unique case (step_r[1:0])
            2'd0: begin
              vol_r  <= vol_c;
              mp_r   <= vol_c[31:0] * item_r.density;
              step_r <= step_r + 1'b1;
            end
            2'd1: begin
              prod_r <= 96'(mp_r);
              mp_r   <= vol_r[63:32] * item_r.density;
              step_r <= step_r + 1'b1;
            end
            2'd2: begin
              prod_r <= prod_r + {mp_r, 32'd0};
              step_r <= step_r + 1'b1;
            end
            default: begin
              mass_r  <= mass_c;
              step_r  <= '0;
              state_r <= S_SHARE;
            end
          endcase
        end
        S_SHARE: begin
          step_r <= step_r + 1'b1;
          if (step_r == SHARE_LAST) begin
            state_r <= S_TOT;
          end
        end
        S_TOT: begin
          vol_tot_r         <= sat_add(vol_tot_r, vol_r);
          mass_tot_r        <= sat_add(mass_tot_r, mass_r);
          res_r.elem_volume <= vol_r;
          res_r.elem_mass   <= mass_r;
          state_r           <= S_DONE;
        end
        S_RDM: begin
          res_r.vertex_mass <= mm_rdata_r;
          state_r           <= S_DONE;
        end
        S_MEAN: begin
          mr_r   <= mr_nxt;
          mn_r   <= {mn_r[30:0], 1'b0};
          mq_r   <= {mq_r[30:0], mge};
          step_r <= step_r + 1'b1;
          if (step_r == MEAN_LAST) begin
            res_r.mean_density <= {mq_r[30:0], mge};
            state_r            <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_res_r   <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
